/* hdl/csi_pkg.sv */
// Shared types and constants for the cone/sphere intersection unit.
// Config register codes, field widths, reset values and the config bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ORG_W           = 32;
  localparam int AX_W            = 16;
  localparam int AXIS_W          = 3 * AX_W;
  localparam int R_W             = 31;
  localparam int SIN_W           = 17;
  localparam int INV_W           = 24;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 48;

  localparam int Q_FRAC    = 16;
  localparam int AXIS_FRAC = 14;
  localparam int COS_SHIFT = 12;
  localparam int QW        = R_W + INV_W - Q_FRAC;

  localparam logic [SIN_W-1:0] SIN_ONE = SIN_W'(65536);
  localparam int Q_ROUND   = 32768;
  localparam int Q14_ROUND = 8192;

  localparam logic [AXIS_W-1:0] AXIS_RST   = AXIS_W'(16384);
  localparam logic [R_W-1:0]    CONE_R_RST = R_W'(65536);
  localparam logic [SIN_W-1:0]  SIN_SQ_RST = SIN_W'(16384);
  localparam logic [INV_W-1:0]  INV_RST    = INV_W'(131072);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_AXIS     = 3'd3,
    REG_CONE_R   = 3'd4,
    REG_SIN_SQ   = 3'd5,
    REG_INV_SIN  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [ORG_W-1:0] org_x;
    logic signed [ORG_W-1:0] org_y;
    logic signed [ORG_W-1:0] org_z;
    logic signed [AX_W-1:0]  ax_x;
    logic signed [AX_W-1:0]  ax_y;
    logic signed [AX_W-1:0]  ax_z;
    logic [R_W-1:0]          cone_r;
    logic [SIN_W-1:0]        sin_cl;
    logic [SIN_W-1:0]        cos_sq;
    logic [INV_W-1:0]        inv_sin;
  } csi_cfg_t;

endpackage

`default_nettype wire

/* hdl/csi_mul.sv */
// Two-stage unsigned multiplier: operands split in halves, partial
// products registered, then summed into a registered full-width product.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module csi_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  wire logic            clk,
  input  wire logic [AW-1:0]   a,
  input  wire logic [BW-1:0]   b,
  output logic [AW+BW-1:0]     p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] pp_ll;
  logic [AL+BH-1:0] pp_lh;
  logic [AH+BL-1:0] pp_hl;
  logic [AH+BH-1:0] pp_hh;

  always_ff @(posedge clk) begin
    pp_ll <= a[AL-1:0] * b[BL-1:0];
    pp_lh <= a[AL-1:0] * b[BW-1:BL];
    pp_hl <= a[AW-1:AL] * b[BL-1:0];
    pp_hh <= a[AW-1:AL] * b[BW-1:BL];
    p     <= (PW'(pp_hh) << (AL + BL)) + (PW'(pp_lh) << BL)
           + (PW'(pp_hl) << AL) + PW'(pp_ll);
  end

endmodule

`default_nettype wire

/* hdl/csi_cfg_regs.sv */
// Configuration register file for the cone/sphere intersection unit.
// Decodes writes, holds the cone, clamps sin^2 and derives cos^2. Uses csi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csi_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [csi_pkg::CFG_IDX_W-1:0]    wr_index,
  input  wire logic [csi_pkg::CFG_DATA_W-1:0]   wr_data,
  output csi_pkg::csi_cfg_t                     cfg
);

  logic [csi_pkg::ORG_W-1:0]  origin_x;
  logic [csi_pkg::ORG_W-1:0]  origin_y;
  logic [csi_pkg::ORG_W-1:0]  origin_z;
  logic [csi_pkg::AXIS_W-1:0] axis_packed;
  logic [csi_pkg::R_W-1:0]    cone_radius;
  logic [csi_pkg::SIN_W-1:0]  sin_sq;
  logic [csi_pkg::INV_W-1:0]  inv_sin;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      origin_z    <= '0;
      axis_packed <= csi_pkg::AXIS_RST;
      cone_radius <= csi_pkg::CONE_R_RST;
      sin_sq      <= csi_pkg::SIN_SQ_RST;
      inv_sin     <= csi_pkg::INV_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        csi_pkg::REG_ORIGIN_X: origin_x    <= wr_data[csi_pkg::ORG_W-1:0];
        csi_pkg::REG_ORIGIN_Y: origin_y    <= wr_data[csi_pkg::ORG_W-1:0];
        csi_pkg::REG_ORIGIN_Z: origin_z    <= wr_data[csi_pkg::ORG_W-1:0];
        csi_pkg::REG_AXIS:     axis_packed <= wr_data[csi_pkg::AXIS_W-1:0];
        csi_pkg::REG_CONE_R:   cone_radius <= wr_data[csi_pkg::R_W-1:0];
        csi_pkg::REG_SIN_SQ:   sin_sq      <= wr_data[csi_pkg::SIN_W-1:0];
        csi_pkg::REG_INV_SIN:  inv_sin     <= wr_data[csi_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.org_x   = $signed(origin_x);
    cfg.org_y   = $signed(origin_y);
    cfg.org_z   = $signed(origin_z);
    cfg.ax_x    = $signed(axis_packed[csi_pkg::AX_W-1:0]);
    cfg.ax_y    = $signed(axis_packed[2*csi_pkg::AX_W-1:csi_pkg::AX_W]);
    cfg.ax_z    = $signed(axis_packed[3*csi_pkg::AX_W-1:2*csi_pkg::AX_W]);
    cfg.cone_r  = cone_radius;
    cfg.sin_cl  = (sin_sq > csi_pkg::SIN_ONE) ? csi_pkg::SIN_ONE : sin_sq;
    cfg.cos_sq  = csi_pkg::SIN_ONE - cfg.sin_cl;
    cfg.inv_sin = inv_sin;
  end

endmodule

`default_nettype wire

/* hdl/cone_sphere_intersect_unit.sv */
// Cone/sphere intersection unit: 12-stage pipeline, one sphere per cycle.
// Throughput: one test per clock; the split multipliers are pipelined, so
// nothing iterates. busy is high only during reset; the receiver cannot stall.
// Synchronous reset clears the valid pipe and loads config reset values.
// Uses csi_pkg, csi_cfg_regs, csi_mul.
`timescale 1ns / 1ps
`default_nettype none

module cone_sphere_intersect_unit #(
  parameter int COORD_WIDTH = csi_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic signed [COORD_WIDTH-1:0]   sphere_x,
  input  wire logic signed [COORD_WIDTH-1:0]   sphere_y,
  input  wire logic signed [COORD_WIDTH-1:0]   sphere_z,
  input  wire logic [csi_pkg::R_W-1:0]         sphere_radius,
  output logic                                 result_valid,
  output logic                                 hit,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [csi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [csi_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CWE   = (COORD_WIDTH > csi_pkg::ORG_W) ? csi_pkg::ORG_W : COORD_WIDTH;
  localparam int AW    = CWE + 1;
  localparam int SQAW  = 2 * AW;
  localparam int DSQW  = SQAW + 2;
  localparam int RRW   = csi_pkg::R_W + 1;
  localparam int DCW   = (DSQW > 2 * RRW) ? DSQW : 2 * RRW;
  localparam int RINVW = csi_pkg::R_W + csi_pkg::INV_W;
  localparam int QW    = csi_pkg::QW;
  localparam int PAW   = AW + csi_pkg::AX_W;
  localparam int E2W   = PAW + 2;
  localparam int DSW   = DSQW + csi_pkg::SIN_W;
  localparam int CW2   = (2 * E2W > DSW + csi_pkg::COS_SHIFT) ?
                         2 * E2W : DSW + csi_pkg::COS_SHIFT;
  localparam int TW    = QW + 1 + csi_pkg::AX_W;
  localparam int OFFW  = TW - csi_pkg::AXIS_FRAC;
  localparam int DW    = ((AW > OFFW) ? AW : OFFW) + 1;
  localparam int PDW   = DW + csi_pkg::AX_W;
  localparam int EW    = PDW + 2;
  localparam int DDSQW = 2 * DW + 2;
  localparam int RHSW  = DDSQW + csi_pkg::SIN_W;
  localparam int CW3   = (2 * EW > RHSW + csi_pkg::COS_SHIFT) ?
                         2 * EW : RHSW + csi_pkg::COS_SHIFT;
  localparam int NST   = 12;

  csi_pkg::csi_cfg_t cfg;

  assign cfg_ready = !rst;
  assign busy      = rst;

  csi_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  logic signed [CWE-1:0]            sph [3];
  logic signed [CWE-1:0]            org [3];
  logic signed [csi_pkg::AX_W-1:0]  ax  [3];

  always_comb begin
    sph[0] = $signed(sphere_x[CWE-1:0]);
    sph[1] = $signed(sphere_y[CWE-1:0]);
    sph[2] = $signed(sphere_z[CWE-1:0]);
    org[0] = $signed(cfg.org_x[CWE-1:0]);
    org[1] = $signed(cfg.org_y[CWE-1:0]);
    org[2] = $signed(cfg.org_z[CWE-1:0]);
    ax[0]  = cfg.ax_x;
    ax[1]  = cfg.ax_y;
    ax[2]  = cfg.ax_z;
  end

  logic [NST:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NST-1:1], start && !busy};
    end
  end

  // stage 1: offset from apex
  logic signed [AW-1:0]     a1 [3];
  logic [AW-1:0]            amag1 [3];
  logic [csi_pkg::R_W-1:0]  r1;
  logic [RRW-1:0]           rr1;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a1[i] <= AW'(sph[i]) - AW'(org[i]);
    end
    r1  <= sphere_radius;
    rr1 <= RRW'(sphere_radius) + RRW'(cfg.cone_r);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag1[i] = a1[i][AW-1] ? AW'(-a1[i]) : AW'(a1[i]);
    end
  end

  logic [SQAW-1:0]  sqa3 [3];
  logic [2*RRW-1:0] rrsq3;
  logic [2*csi_pkg::R_W-1:0] rsq3;
  logic [RINVW-1:0] rinv3;

  for (genvar g = 0; g < 3; g++) begin : g_sqa
    csi_mul #(.AW(AW), .BW(AW)) u_sq (
      .clk (clk), .a (amag1[g]), .b (amag1[g]), .p (sqa3[g])
    );
  end

  csi_mul #(.AW(RRW), .BW(RRW)) u_rrsq (
    .clk (clk), .a (rr1), .b (rr1), .p (rrsq3)
  );

  csi_mul #(.AW(csi_pkg::R_W), .BW(csi_pkg::R_W)) u_rsq (
    .clk (clk), .a (r1), .b (r1), .p (rsq3)
  );

  csi_mul #(.AW(csi_pkg::R_W), .BW(csi_pkg::INV_W)) u_rinv (
    .clk (clk), .a (r1), .b (cfg.inv_sin), .p (rinv3)
  );

  // stages 2..4: behind-apex dot, |A|^2, shift length
  logic signed [PAW-1:0]  pa2 [3];
  logic signed [AW-1:0]   a2 [3];
  logic signed [AW-1:0]   a3 [3];
  logic signed [AW-1:0]   a4 [3];
  logic signed [E2W-1:0]  e2_3;
  logic signed [E2W-1:0]  e2_4;
  logic [DSQW-1:0]        dsq4;
  logic [QW-1:0]          q4;
  logic [2*RRW-1:0]       rrsq4;
  logic [2*csi_pkg::R_W-1:0] rsq4;
  logic [RINVW-1:0]       rinv_rnd;
  logic [E2W-1:0]         e2mag4;

  assign rinv_rnd = rinv3 + RINVW'(csi_pkg::Q_ROUND);
  assign e2mag4   = e2_4[E2W-1] ? E2W'(-e2_4) : E2W'(e2_4);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pa2[i] <= PAW'(ax[i]) * PAW'(a1[i]);
      a2[i]  <= a1[i];
      a3[i]  <= a2[i];
      a4[i]  <= a3[i];
    end
    e2_3  <= -(E2W'(pa2[0]) + E2W'(pa2[1]) + E2W'(pa2[2]));
    e2_4  <= e2_3;
    dsq4  <= DSQW'(sqa3[0]) + DSQW'(sqa3[1]) + DSQW'(sqa3[2]);
    q4    <= rinv_rnd[csi_pkg::Q_FRAC +: QW];
    rrsq4 <= rrsq3;
    rsq4  <= rsq3;
  end

  logic [2*E2W-1:0] e2sq6;
  logic [DSW-1:0]   dsqs6;

  csi_mul #(.AW(E2W), .BW(E2W)) u_e2sq (
    .clk (clk), .a (e2mag4), .b (e2mag4), .p (e2sq6)
  );

  csi_mul #(.AW(DSQW), .BW(csi_pkg::SIN_W)) u_dsqs (
    .clk (clk), .a (dsq4), .b (cfg.sin_cl), .p (dsqs6)
  );

  // stages 5..6: bounding reject, shifted apex offset D
  logic                 rej5, in5, e2pos5;
  logic signed [TW-1:0] t5 [3];
  logic signed [AW-1:0] a5 [3];
  logic signed [TW-1:0] tr5 [3];
  logic signed [DW-1:0] d6 [3];
  logic [DW-1:0]        dmag6 [3];
  logic                 rej6, in6, e2pos6;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tr5[i]   = t5[i] + TW'(csi_pkg::Q14_ROUND);
      dmag6[i] = d6[i][DW-1] ? DW'(-d6[i]) : DW'(d6[i]);
    end
  end

  always_ff @(posedge clk) begin
    rej5   <= DCW'(dsq4) > DCW'(rrsq4);
    in5    <= DCW'(dsq4) <= DCW'(rsq4);
    e2pos5 <= !e2_4[E2W-1] && (e2_4 != '0);
    for (int i = 0; i < 3; i++) begin
      t5[i] <= TW'($signed({1'b0, q4})) * TW'(ax[i]);
      a5[i] <= a4[i];
      d6[i] <= DW'(a5[i]) + DW'($signed(tr5[i][TW-1:csi_pkg::AXIS_FRAC]));
    end
    rej6   <= rej5;
    in6    <= in5;
    e2pos6 <= e2pos5;
  end

  logic [2*DW-1:0] sqd8 [3];

  for (genvar g = 0; g < 3; g++) begin : g_sqd
    csi_mul #(.AW(DW), .BW(DW)) u_sq (
      .clk (clk), .a (dmag6[g]), .b (dmag6[g]), .p (sqd8[g])
    );
  end

  // stages 7..11: behind-apex verdict, cone test on D
  logic                  bh7, rej7;
  logic signed [PDW-1:0] pd7 [3];
  logic signed [EW-1:0]  e8;
  logic                  bh8, rej8;
  logic [DDSQW-1:0]      dsqd9;
  logic [EW-1:0]         emag9;
  logic                  epos9, bh9, rej9;
  logic                  epos10, bh10, rej10;
  logic                  epos11, bh11, rej11;

  always_ff @(posedge clk) begin
    bh7  <= (e2pos6 && (CW2'(e2sq6) >= (CW2'(dsqs6) << csi_pkg::COS_SHIFT))) ? in6 : 1'b1;
    rej7 <= rej6;
    for (int i = 0; i < 3; i++) begin
      pd7[i] <= PDW'(ax[i]) * PDW'(d6[i]);
    end
    e8    <= EW'(pd7[0]) + EW'(pd7[1]) + EW'(pd7[2]);
    bh8   <= bh7;
    rej8  <= rej7;
    dsqd9 <= DDSQW'(sqd8[0]) + DDSQW'(sqd8[1]) + DDSQW'(sqd8[2]);
    emag9 <= e8[EW-1] ? EW'(-e8) : EW'(e8);
    epos9 <= !e8[EW-1] && (e8 != '0);
    bh9   <= bh8;
    rej9  <= rej8;
    epos10 <= epos9;
    bh10   <= bh9;
    rej10  <= rej9;
    epos11 <= epos10;
    bh11   <= bh10;
    rej11  <= rej10;
  end

  logic [2*EW-1:0] esq11;
  logic [RHSW-1:0] rhs11;

  csi_mul #(.AW(EW), .BW(EW)) u_esq (
    .clk (clk), .a (emag9), .b (emag9), .p (esq11)
  );

  csi_mul #(.AW(DDSQW), .BW(csi_pkg::SIN_W)) u_rhs (
    .clk (clk), .a (dsqd9), .b (cfg.cos_sq), .p (rhs11)
  );

  // stage 12: result beat
  always_ff @(posedge clk) begin
    hit <= !rej11 && epos11 && bh11
        && (CW3'(esq11) >= (CW3'(rhs11) << csi_pkg::COS_SHIFT));
  end

  assign result_valid = vld[NST];

`ifndef SYNTHESIS
  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##12 result_valid)
    else $error("accepted sphere produced no result beat");

  a_lat_back: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, 12))
    else $error("result beat without a matching accepted sphere");

  a_reject_miss: assert property (@(posedge clk) disable iff (rst)
    (vld[5] && rej5) |-> ##7 (result_valid && !hit))
    else $error("bounding reject did not give a miss");

  a_behind_miss: assert property (@(posedge clk) disable iff (rst)
    (vld[7] && !bh7) |-> ##5 (result_valid && !hit))
    else $error("behind-apex miss not carried to the result");

  a_cone_miss: assert property (@(posedge clk) disable iff (rst)
    (vld[11] && !epos11) |=> (result_valid && !hit))
    else $error("non-positive axial distance gave a hit");
`endif

endmodule

`default_nettype wire
